// File: sv/wal_replay_record_checker_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the write-ahead-log record checker
// Concurrent assertion shorthands. Defining ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef WAL_REPLAY_RECORD_CHECKER_TOP_DEFINES_SVH
`define WAL_REPLAY_RECORD_CHECKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define WRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define WRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define WRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/wrc_pkg.sv
// ---------------------------------------------------------------------------
// wrc_pkg
// Types, constants and the CRC byte update shared by the log record checker.
// ---------------------------------------------------------------------------
package wrc_pkg;

    localparam int LENGTH_BITS_DEFAULT = 21;
    localparam int LEN_W    = 21;
    localparam int OFFSET_W = 48;
    localparam int COUNT_W  = 32;

    localparam logic [31:0]      LOG_MAGIC          = 32'h5741_4C31;
    localparam logic [31:0]      CRC_POLY           = 32'hEDB8_8320;
    localparam logic [31:0]      CRC_INIT           = 32'hFFFF_FFFF;
    localparam int               HEADER_BYTES       = 13;
    localparam logic [LEN_W-1:0] DEFAULT_MAX_LENGTH = 21'h10_0000;
    localparam logic [7:0]       TYPE_PUT           = 8'd1;
    localparam logic [7:0]       TYPE_DEL           = 8'd2;

    // Result codes.
    localparam logic [2:0] EV_PUT       = 3'd0;
    localparam logic [2:0] EV_DEL       = 3'd1;
    localparam logic [2:0] EV_OTHER     = 3'd2;
    localparam logic [2:0] EV_CLEAN_END = 3'd3;
    localparam logic [2:0] EV_TORN      = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_log;
    } wrc_in_t;

    typedef struct packed {
        logic [2:0]          event_res;
        logic [OFFSET_W-1:0] record_offset;
        logic [LEN_W-1:0]    key_length;
        logic [LEN_W-1:0]    value_length;
        logic [COUNT_W-1:0]  put_total;
        logic [COUNT_W-1:0]  del_total;
    } wrc_out_t;

    // Reflected CRC-32, one byte folded in.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        int          i;
        c = crc ^ {24'd0, b};
        for (i = 0; i < 8; i++) begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// File: sv/wrc_parser.sv
// ---------------------------------------------------------------------------
// wrc_parser
// Record state machine: header fields, key and value CRC, trailer check and
// the per-log counters. Result for the current byte is combinational.
// ---------------------------------------------------------------------------
module wrc_parser
    import wrc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  wrc_in_t          item,
    input  logic [LEN_W-1:0] max_length,
    output logic             res_valid,
    output wrc_out_t         res,
    output logic             torn
);

    localparam int LB = LENGTH_BITS;
    localparam logic [32:0] LEN_CAP = (33'd1 << LB) - 33'd1;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_KEY    = 5'b00010,
        PH_VALUE  = 5'b00100,
        PH_CRC    = 5'b01000,
        PH_TORN   = 5'b10000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LB-1:0]       field_count_reg, field_count_next;
    logic [31:0]         shift_word_reg, shift_word_next;
    logic [7:0]          record_type_reg, record_type_next;
    logic [LB-1:0]       key_len_reg, key_len_next;
    logic [LB-1:0]       value_len_reg, value_len_next;
    logic [31:0]         crc_reg, crc_next;
    logic [OFFSET_W-1:0] start_offset_reg, start_offset_next;
    logic [COUNT_W-1:0]  put_count_reg, put_count_next;
    logic [COUNT_W-1:0]  del_count_reg, del_count_next;

    logic [32:0]         limit;
    logic [31:0]         shifted;
    logic [31:0]         crc_upd;
    logic [LB-1:0]       count_inc;
    logic [32:0]         len_sum;
    logic [OFFSET_W-1:0] rec_len;
    logic [OFFSET_W:0]   offset_sum;

    assign torn = (phase_reg == PH_TORN);

    always_comb
    begin
        limit      = (33'(max_length) < LEN_CAP) ? 33'(max_length) : LEN_CAP;
        shifted    = {shift_word_reg[23:0], item.data_byte};
        crc_upd    = crc32_byte(crc_reg, item.data_byte);
        count_inc  = field_count_reg + LB'(1);
        len_sum    = 33'(key_len_reg) + 33'(shifted);
        rec_len    = OFFSET_W'(HEADER_BYTES) + OFFSET_W'(key_len_reg)
                   + OFFSET_W'(value_len_reg) + OFFSET_W'(4);
        offset_sum = {1'b0, start_offset_reg} + {1'b0, rec_len};
    end

    always_comb
    begin
        phase_next        = phase_reg;
        field_count_next  = field_count_reg;
        shift_word_next   = shift_word_reg;
        record_type_next  = record_type_reg;
        key_len_next      = key_len_reg;
        value_len_next    = value_len_reg;
        crc_next          = crc_reg;
        start_offset_next = start_offset_reg;
        put_count_next    = put_count_reg;
        del_count_next    = del_count_reg;

        res_valid         = 1'b0;
        res.event_res     = EV_TORN;
        res.record_offset = start_offset_reg;
        res.key_length    = '0;
        res.value_length  = '0;
        res.put_total     = put_count_reg;
        res.del_total     = del_count_reg;

        if (step) begin
            if (item.end_of_log) begin
                // End marker: report unless already torn, then start a fresh log.
                if (phase_reg != PH_TORN) begin
                    res_valid = 1'b1;
                    if (phase_reg == PH_HEADER && field_count_reg == '0) begin
                        res.event_res = EV_CLEAN_END;
                    end
                end
                phase_next        = PH_HEADER;
                field_count_next  = '0;
                shift_word_next   = '0;
                record_type_next  = '0;
                key_len_next      = '0;
                value_len_next    = '0;
                crc_next          = CRC_INIT;
                start_offset_next = '0;
                put_count_next    = '0;
                del_count_next    = '0;
            end else begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        shift_word_next  = shifted;
                        field_count_next = count_inc;
                        if (field_count_reg >= LB'(4)) begin
                            crc_next = crc_upd;
                        end
                        if (count_inc == LB'(4)) begin
                            if (shifted != LOG_MAGIC) begin
                                phase_next = PH_TORN;
                                res_valid  = 1'b1;
                            end
                        end else if (count_inc == LB'(5)) begin
                            record_type_next = item.data_byte;
                        end else if (count_inc == LB'(9)) begin
                            if (33'(shifted) > limit) begin
                                phase_next = PH_TORN;
                                res_valid  = 1'b1;
                            end else begin
                                key_len_next = shifted[LB-1:0];
                            end
                        end else if (count_inc == LB'(HEADER_BYTES)) begin
                            if (33'(shifted) > limit || len_sum > limit) begin
                                phase_next = PH_TORN;
                                res_valid  = 1'b1;
                            end else begin
                                value_len_next   = shifted[LB-1:0];
                                field_count_next = '0;
                                shift_word_next  = '0;
                                if (key_len_reg != '0) begin
                                    phase_next = PH_KEY;
                                end else if (shifted != '0) begin
                                    phase_next = PH_VALUE;
                                end else begin
                                    phase_next = PH_CRC;
                                end
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        crc_next         = crc_upd;
                        field_count_next = count_inc;
                        if (count_inc == key_len_reg) begin
                            field_count_next = '0;
                            phase_next = (value_len_reg != '0) ? PH_VALUE : PH_CRC;
                        end
                    end
                    PH_VALUE:
                    begin
                        crc_next         = crc_upd;
                        field_count_next = count_inc;
                        if (count_inc == value_len_reg) begin
                            field_count_next = '0;
                            phase_next       = PH_CRC;
                        end
                    end
                    PH_CRC:
                    begin
                        shift_word_next  = shifted;
                        field_count_next = count_inc;
                        if (count_inc == LB'(4)) begin
                            res_valid = 1'b1;
                            if (shifted != ~crc_reg) begin
                                phase_next = PH_TORN;
                            end else begin
                                if (record_type_reg == TYPE_PUT) begin
                                    res.event_res = EV_PUT;
                                    if (put_count_reg != '1) begin
                                        put_count_next = put_count_reg + COUNT_W'(1);
                                    end
                                end else if (record_type_reg == TYPE_DEL) begin
                                    res.event_res = EV_DEL;
                                    if (del_count_reg != '1) begin
                                        del_count_next = del_count_reg + COUNT_W'(1);
                                    end
                                end else begin
                                    res.event_res = EV_OTHER;
                                end
                                res.key_length    = LEN_W'(key_len_reg);
                                res.value_length  = LEN_W'(value_len_reg);
                                res.put_total     = put_count_next;
                                res.del_total     = del_count_next;
                                start_offset_next = offset_sum[OFFSET_W] ? '1
                                                  : offset_sum[OFFSET_W-1:0];
                                phase_next        = PH_HEADER;
                                field_count_next  = '0;
                                shift_word_next   = '0;
                                crc_next          = CRC_INIT;
                            end
                        end
                    end
                    default:
                    begin
                        // Torn: bytes are dropped until the end marker.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_HEADER;
            field_count_reg  <= '0;
            shift_word_reg   <= '0;
            record_type_reg  <= '0;
            key_len_reg      <= '0;
            value_len_reg    <= '0;
            crc_reg          <= CRC_INIT;
            start_offset_reg <= '0;
            put_count_reg    <= '0;
            del_count_reg    <= '0;
        end else begin
            phase_reg        <= phase_next;
            field_count_reg  <= field_count_next;
            shift_word_reg   <= shift_word_next;
            record_type_reg  <= record_type_next;
            key_len_reg      <= key_len_next;
            value_len_reg    <= value_len_next;
            crc_reg          <= crc_next;
            start_offset_reg <= start_offset_next;
            put_count_reg    <= put_count_next;
            del_count_reg    <= del_count_next;
        end
    end

endmodule

// File: sv/wal_replay_record_checker_top.sv
// ---------------------------------------------------------------------------
// wal_replay_record_checker_top
// Byte-serial checker for write-ahead-log records with CRC-32 trailers.
// ---------------------------------------------------------------------------
// The checker takes one log byte (or one end marker) per word and sustains one
// word per clock cycle while results are taken. A word is captured in an input
// register and then processed by the record state machine; any result lands in
// an output register at the end of the cycle that processes its word, and is
// offered from there. The cycle that bounds the clock is the byte-wide CRC-32
// update together with the header length compares feeding the record state. A
// result that is not taken stalls the input register, and the input register
// stalls the input port, so no word is ever dropped. Each well-formed record
// yields one result when its last CRC byte arrives; a bad magic, an oversized
// length or a CRC mismatch yields one torn result at the record's start offset,
// after which bytes are ignored until the end marker. Unless the log is already
// torn, the end marker yields a clean-end or torn result; it clears all per-log
// state either way, and max_length survives it.
module wal_replay_record_checker_top
    import wrc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  wrc_in_t          item,
    output logic             result_valid,
    input  logic             result_ready,
    output wrc_out_t         result,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

`include "wal_replay_record_checker_top_defines.svh"

    // Configuration register: the length limit for keys, values and their sum.
    logic [LEN_W-1:0] max_length_reg;

    // Input stage.
    logic    s1_valid_reg, s1_valid_next;
    wrc_in_t s1_reg;

    // Output stage.
    logic     out_valid_reg, out_valid_next;
    wrc_out_t out_reg;

    // The parser advances when the input stage holds a word and the output
    // register is empty or being emptied in this cycle.
    logic     step;
    logic     res_valid;
    wrc_out_t res;
    logic     torn;

    assign step         = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || step;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    wrc_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (s1_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res),
        .torn       (torn)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_valid && item_ready) begin
            s1_valid_next = 1'b1;
        end else if (step) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = res_valid;
        end else if (result_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_length_reg <= DEFAULT_MAX_LENGTH;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_length_reg <= cfg_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready) begin
            s1_reg <= item;
        end
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    // A result is only produced by a word that actually advances the parser.
    `WRC_ASSERT_SAME(a_result_needs_step, clk, rst_n, res_valid, step,
        "parser result without an advancing word")

    // Once torn, plain bytes never produce a result.
    `WRC_ASSERT_SAME(a_torn_is_silent, clk, rst_n, step && torn && !s1_reg.end_of_log,
        !res_valid, "result produced while the log is torn")

    // A stalled input stage keeps its word.
    `WRC_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !step,
        s1_valid_reg && $stable(s1_reg), "input stage lost or changed a stalled word")

    // A reported PUT is always counted.
    `WRC_ASSERT_SAME(a_put_counted, clk, rst_n, out_valid_reg && out_reg.event_res == EV_PUT,
        out_reg.put_total != '0, "PUT result with a zero PUT count")

endmodule

// File: sim/wal_replay_record_checker_top_tb.sv
// ---------------------------------------------------------------------------
// wal_replay_record_checker_top_tb
// Drives log streams of framed records into the record checker one byte per
// word and checks every result word against a cycle-free model of the record
// state, the CRC and the running PUT and DEL totals kept by a scoreboard.
// ---------------------------------------------------------------------------
module wal_replay_record_checker_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wrc_pkg::*;

    // Where the model stands within the current record.
    typedef enum logic [2:0] {
        SEEK_HEADER,
        SEEK_KEY,
        SEEK_VALUE,
        SEEK_CRC,
        SEEK_TORN
    } seek_t;

    // Ways in which a generated record can be broken on purpose.
    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_CRC
    } flaw_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_WORDS = 224;
    localparam int REPORT_LIMIT = 10;

    // -----------------------------------------------------------------------
    // Scoreboard: tracks the record state word by word and keeps the results
    // that are still owed by the block, oldest first.
    // -----------------------------------------------------------------------
    class wal_event_scoreboard;
        logic [LEN_W-1:0]    max_len;
        seek_t               phase;
        int unsigned         field_cnt;
        logic [31:0]         shift_reg;
        logic [7:0]          rec_type;
        logic [31:0]         key_len;
        logic [31:0]         val_len;
        logic [31:0]         crc;
        logic [OFFSET_W-1:0] start_off;
        logic [COUNT_W-1:0]  puts;
        logic [COUNT_W-1:0]  dels;
        bit                  poisoned;
        wrc_out_t            expected_events[$];
        int                  failures;

        function new();
            max_len = DEFAULT_MAX_LENGTH;
            failures = 0;
            clear_log();
        endfunction

        static function logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] acc;
            acc = c ^ {24'd0, b};
            for (int i = 0; i < 8; i++) begin
                acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0]}});
            end
            return acc;
        endfunction

        function void clear_log();
            phase = SEEK_HEADER;
            field_cnt = 0;
            shift_reg = '0;
            rec_type = '0;
            key_len = '0;
            val_len = '0;
            crc = CRC_INIT;
            start_off = '0;
            puts = '0;
            dels = '0;
            poisoned = 1'b0;
        endfunction

        // The register is no wider than the length store, so this is the
        // register itself unless the store is made narrower.
        function logic [32:0] limit_val();
            logic [32:0] cap;
            cap = (33'd1 << LENGTH_BITS_DEFAULT) - 33'd1;
            return ({12'd0, max_len} < cap) ? {12'd0, max_len} : cap;
        endfunction

        function void post(input logic [2:0] ev, input logic [31:0] k, input logic [31:0] v);
            wrc_out_t e;
            e.event_res = ev;
            e.record_offset = start_off;
            e.key_length = k[LEN_W-1:0];
            e.value_length = v[LEN_W-1:0];
            e.put_total = puts;
            e.del_total = dels;
            expected_events.push_back(e);
        endfunction

        function void go_torn();
            phase = SEEK_TORN;
            poisoned = 1'b1;
            post(EV_TORN, 32'd0, 32'd0);
        endfunction

        function void take_word(input wrc_in_t w);
            logic [7:0]          b;
            logic [32:0]         lim;
            logic [2:0]          ev;
            logic [OFFSET_W:0]   nxt;
            b = w.data_byte;
            lim = limit_val();
            if (w.end_of_log) begin
                if (!poisoned) begin
                    if (phase == SEEK_HEADER && field_cnt == 0)
                        post(EV_CLEAN_END, 32'd0, 32'd0);
                    else
                        post(EV_TORN, 32'd0, 32'd0);
                end
                clear_log();
                return;
            end
            if (poisoned || phase == SEEK_TORN)
                return;
            case (phase)
                SEEK_HEADER:
                begin
                    shift_reg = {shift_reg[23:0], b};
                    if (field_cnt >= 4)
                        crc = crc_fold(crc, b);
                    field_cnt++;
                    if (field_cnt == 4) begin
                        if (shift_reg != LOG_MAGIC)
                            go_torn();
                    end else if (field_cnt == 5) begin
                        rec_type = b;
                    end else if (field_cnt == 9) begin
                        if ({1'b0, shift_reg} > lim)
                            go_torn();
                        else
                            key_len = shift_reg;
                    end else if (field_cnt == HEADER_BYTES) begin
                        if (({1'b0, shift_reg} > lim) ||
                            ({1'b0, key_len} + {1'b0, shift_reg} > lim)) begin
                            go_torn();
                        end else begin
                            val_len = shift_reg;
                            field_cnt = 0;
                            shift_reg = '0;
                            if (key_len != 0)
                                phase = SEEK_KEY;
                            else if (val_len != 0)
                                phase = SEEK_VALUE;
                            else
                                phase = SEEK_CRC;
                        end
                    end
                end
                SEEK_KEY:
                begin
                    crc = crc_fold(crc, b);
                    field_cnt++;
                    if (field_cnt >= key_len) begin
                        field_cnt = 0;
                        phase = (val_len != 0) ? SEEK_VALUE : SEEK_CRC;
                    end
                end
                SEEK_VALUE:
                begin
                    crc = crc_fold(crc, b);
                    field_cnt++;
                    if (field_cnt >= val_len) begin
                        field_cnt = 0;
                        phase = SEEK_CRC;
                    end
                end
                default:
                begin
                    shift_reg = {shift_reg[23:0], b};
                    field_cnt++;
                    if (field_cnt < 4)
                        return;
                    if (shift_reg != ~crc) begin
                        go_torn();
                        return;
                    end
                    if (rec_type == TYPE_PUT) begin
                        ev = EV_PUT;
                        if (puts != '1)
                            puts++;
                    end else if (rec_type == TYPE_DEL) begin
                        ev = EV_DEL;
                        if (dels != '1)
                            dels++;
                    end else begin
                        ev = EV_OTHER;
                    end
                    post(ev, key_len, val_len);
                    nxt = {1'b0, start_off} + HEADER_BYTES + key_len + val_len + 4;
                    if (nxt > {1'b0, {OFFSET_W{1'b1}}})
                        start_off = '1;
                    else
                        start_off = nxt[OFFSET_W-1:0];
                    phase = SEEK_HEADER;
                    field_cnt = 0;
                    shift_reg = '0;
                    crc = CRC_INIT;
                end
            endcase
        endfunction

        function void check_event(input wrc_out_t got);
            wrc_out_t want;
            bit       bad;
            if (expected_events.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: event %0d offset %0h key %0d value %0d",
                             got.event_res, got.record_offset, got.key_length,
                             got.value_length);
                return;
            end
            want = expected_events.pop_front();
            bad = (got.event_res !== want.event_res) ||
                  (got.record_offset !== want.record_offset) ||
                  (got.key_length !== want.key_length) ||
                  (got.value_length !== want.value_length) ||
                  (got.put_total !== want.put_total) ||
                  (got.del_total !== want.del_total);
            if (bad) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("mismatch: expected ev %0d off %0h key %0d val %0d put %0d del %0d",
                             want.event_res, want.record_offset, want.key_length,
                             want.value_length, want.put_total, want.del_total);
                    $display("          actual   ev %0d off %0h key %0d val %0d put %0d del %0d",
                             got.event_res, got.record_offset, got.key_length,
                             got.value_length, got.put_total, got.del_total);
                end
            end
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals around the block.
    // -----------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    wrc_in_t          item;
    logic             result_valid;
    logic             result_ready;
    wrc_out_t         result;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int words_sent;
    int cycle_count;

    // The record being built for sending, and its running CRC.
    logic [7:0]  rec_bytes[$];
    logic [31:0] rec_crc;

    wal_event_scoreboard sb;

    wal_replay_record_checker_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Both monitors sample at the rising edge, so they see the same values
    // the block uses to decide whether a word moves.
    always @(posedge clk) begin
        if (rst_n && item_valid && item_ready)
            sb.take_word(item);
    end

    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready)
            sb.check_event(result);
    end

    // The receiver stalls at random. A hold-off request from the main
    // process keeps ready low for a counted stretch, long enough for the
    // block to fill up and push back on the sender.
    initial begin
        result_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                result_ready <= 1'b0;
                hold_left--;
            end else begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog. A correct run ends far below this count.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("wal_replay_record_checker_top_tb: FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Record building.
    // -----------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        rec_bytes.push_back(b);
        rec_crc = wal_event_scoreboard::crc_fold(rec_crc, b);
    endfunction

    // Fills rec_bytes with one framed record. A record whose lengths are too
    // large to carry is cut after the header, since the block gives up there.
    function automatic void build_record(input logic [7:0] rtype, input logic [31:0] klen,
                                         input logic [31:0] vlen, input flaw_t flaw);
        logic [31:0] magic;
        logic [31:0] trailer;
        logic [31:0] mask;
        logic [32:0] body;
        rec_bytes.delete();
        magic = LOG_MAGIC;
        if (flaw == FLAW_MAGIC)
            magic = magic ^ (32'd1 << $urandom_range(31));
        for (int i = 3; i >= 0; i--)
            rec_bytes.push_back(magic[8*i +: 8]);
        rec_crc = CRC_INIT;
        add_byte(rtype);
        for (int i = 3; i >= 0; i--)
            add_byte(klen[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            add_byte(vlen[8*i +: 8]);
        body = {1'b0, klen} + {1'b0, vlen};
        if (body > 64)
            return;
        for (int i = 0; i < body; i++)
            add_byte(8'($urandom));
        trailer = ~rec_crc;
        if (flaw == FLAW_CRC) begin
            mask = $urandom;
            if (mask == 0)
                mask = 32'd1;
            trailer = trailer ^ mask;
        end
        for (int i = 3; i >= 0; i--)
            rec_bytes.push_back(trailer[8*i +: 8]);
    endfunction

    // -----------------------------------------------------------------------
    // Driving. Every task starts and ends right at a rising edge.
    // -----------------------------------------------------------------------

    // Offers one word and returns at the edge where it is taken. Ready is
    // looked at on the falling edge, where it has settled for the coming
    // rising edge.
    task automatic send_word(input wrc_in_t w);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = item_ready;
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        wrc_in_t w;
        w.data_byte = b;
        w.end_of_log = 1'b0;
        send_word(w);
    endtask

    // The byte lane is don't-care with the end marker, so it carries noise.
    task automatic send_end();
        wrc_in_t w;
        w.data_byte = 8'($urandom);
        w.end_of_log = 1'b1;
        send_word(w);
    endtask

    task automatic send_rec(input int count);
        for (int i = 0; i < count && i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i]);
    endtask

    task automatic send_whole(input logic [7:0] rtype, input logic [31:0] klen,
                              input logic [31:0] vlen, input flaw_t flaw);
        build_record(rtype, klen, vlen, flaw);
        send_rec(rec_bytes.size());
    endtask

    // Bytes after a torn record must be ignored up to the end marker.
    task automatic send_junk_and_end();
        repeat ($urandom_range(5))
            send_byte(8'($urandom));
        send_end();
    endtask

    // The sender goes quiet until every result has come back, then gives the
    // block time to retire any word that causes no result.
    task automatic quiesce();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LEN_W-1:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.max_len = v;
    endtask

    // -----------------------------------------------------------------------
    // Random stimulus.
    // -----------------------------------------------------------------------
    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return TYPE_PUT;
        else if (r < 75)
            return TYPE_DEL;
        return 8'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] pick_limit();
        case ($urandom_range(4))
            0: return DEFAULT_MAX_LENGTH;
            1: return '1;
            2: return '0;
            3: return LEN_W'($urandom_range(40, 1));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] over_limit(input logic [31:0] lim);
        if ($urandom_range(1) == 0)
            return lim + 32'd1;
        return $urandom | (lim + 32'd1);
    endfunction

    // Lengths that pass the limit. Mostly short, now and then a longer
    // record, and sometimes the pair fills the span exactly.
    task automatic choose_lengths(input logic [31:0] lim, output logic [31:0] k,
                                  output logic [31:0] v);
        logic [31:0] span;
        span = ($urandom_range(9) == 0) ? 32'd40 : 32'd10;
        if (span > lim)
            span = lim;
        k = $urandom_range(span, 0);
        if ($urandom_range(19) == 0)
            v = span - k;
        else
            v = $urandom_range(span - k, 0);
    endtask

    task automatic random_record();
        int          pick;
        int          sel;
        logic [31:0] lim;
        logic [31:0] k;
        logic [31:0] v;
        pick = $urandom_range(99);
        lim = 32'(sb.limit_val());
        choose_lengths(lim, k, v);
        if (pick < 70) begin
            send_whole(pick_type(), k, v, FLAW_NONE);
        end else if (pick < 76) begin
            send_whole(pick_type(), k, v, FLAW_MAGIC);
            send_junk_and_end();
        end else if (pick < 82) begin
            send_whole(pick_type(), k, v, FLAW_CRC);
            send_junk_and_end();
        end else if (pick < 88) begin
            // Key too long, value too long, or each fine but the sum too long.
            sel = $urandom_range(2);
            if (sel == 2 && lim != 0) begin
                k = $urandom_range(lim, 1);
                v = lim - k + 32'd1 + $urandom_range(k - 1, 0);
            end else if (sel == 1) begin
                k = $urandom_range((lim < 4) ? lim : 4, 0);
                v = over_limit(lim);
            end else begin
                k = over_limit(lim);
                v = $urandom;
            end
            send_whole(pick_type(), k, v, FLAW_NONE);
            send_junk_and_end();
        end else if (pick < 93) begin
            // The log stops somewhere inside a record.
            build_record(pick_type(), k, v, FLAW_NONE);
            send_rec($urandom_range(rec_bytes.size() - 1, 1));
            send_end();
        end else if (pick < 97) begin
            send_end();
        end else begin
            send_junk_and_end();
        end
    endtask

    // Two limit settings per phase, with the block drained before each write.
    task automatic random_phase(input int sidle, input int ridle, input bit pressure);
        int target;
        bit held;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        held = 1'b0;
        repeat (2) begin
            quiesce();
            set_limit(pick_limit());
            target = words_sent + PHASE_WORDS / 2;
            while (words_sent < target) begin
                if (pressure && !held && words_sent > target - PHASE_WORDS / 4) begin
                    hold_left = HOLD_OFF_CYCLES;
                    held = 1'b1;
                end
                random_record();
            end
            send_end();
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------
    initial begin
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        words_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset limit. An empty log ends cleanly at 0.
        send_end();
        send_whole(TYPE_PUT, 32'd0, 32'd0, FLAW_NONE);
        send_whole(TYPE_DEL, 32'd2, 32'd3, FLAW_NONE);
        send_whole(8'hFF, 32'd1, 32'd0, FLAW_NONE);
        send_whole(8'h00, 32'd0, 32'd2, FLAW_NONE);
        send_end();
        // Bad magic, with a stray byte that must be swallowed.
        send_whole(TYPE_PUT, 32'd1, 32'd1, FLAW_MAGIC);
        send_byte(8'hA5);
        send_end();
        send_whole(TYPE_DEL, 32'd3, 32'd1, FLAW_CRC);
        send_end();
        // Largest header lengths, caught in the header.
        send_whole(TYPE_PUT, 32'hFFFF_FFFF, 32'd0, FLAW_NONE);
        send_end();
        send_whole(TYPE_PUT, 32'd0, 32'hFFFF_FFFF, FLAW_NONE);
        send_end();
        // The log ends inside the key, inside the header and inside the CRC.
        build_record(TYPE_PUT, 32'd4, 32'd4, FLAW_NONE);
        send_rec(15);
        send_end();
        send_rec(2);
        send_end();
        send_whole(TYPE_DEL, 32'd1, 32'd1, FLAW_NONE);
        build_record(TYPE_PUT, 32'd2, 32'd0, FLAW_NONE);
        send_rec(rec_bytes.size() - 1);
        send_end();

        // A small limit: both lengths right at it, the sum past it, each past it.
        quiesce();
        set_limit(21'd4);
        send_whole(TYPE_PUT, 32'd4, 32'd0, FLAW_NONE);
        send_whole(TYPE_DEL, 32'd0, 32'd4, FLAW_NONE);
        send_whole(TYPE_PUT, 32'd1, 32'd3, FLAW_NONE);
        send_whole(TYPE_PUT, 32'd3, 32'd2, FLAW_NONE);
        send_end();
        send_whole(TYPE_PUT, 32'd5, 32'd0, FLAW_NONE);
        send_end();
        send_whole(TYPE_DEL, 32'd0, 32'd5, FLAW_NONE);
        send_end();

        // A zero limit admits only empty records.
        quiesce();
        set_limit('0);
        send_whole(TYPE_PUT, 32'd0, 32'd0, FLAW_NONE);
        send_whole(TYPE_PUT, 32'd1, 32'd0, FLAW_NONE);
        send_end();

        quiesce();
        set_limit('1);
        send_whole(TYPE_PUT, 32'd2, 32'd2, FLAW_NONE);
        send_end();

        // Random part: receiver idles more, then sender idles more, then
        // full rate with one long receiver hold-off.
        random_phase(36, 50, 1'b0);
        random_phase(50, 36, 1'b0);
        random_phase(0, 0, 1'b1);

        quiesce();
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("wal_replay_record_checker_top_tb: PASS");
        else
            $display("wal_replay_record_checker_top_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/wrc_pkg.sv
sv/wrc_parser.sv
sv/wal_replay_record_checker_top.sv
sim/wal_replay_record_checker_top_tb.sv
